FILE: hdl/jrim_pkg.sv
package jrim_pkg;

    typedef enum logic [2:0] {
        CMD_LOAD    = 3'd0,
        CMD_APPEND  = 3'd1,
        CMD_LATEST  = 3'd2,
        CMD_NEXT    = 3'd3,
        CMD_PREV    = 3'd4,
        CMD_INDEX   = 3'd5,
        CMD_RECOVER = 3'd6,
        CMD_RSTHEAD = 3'd7
    } t_cmd;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_TOO_MANY  = 3'd2;
    localparam logic [2:0] ST_BAD_INDEX = 3'd3;
    localparam logic [2:0] ST_WRITE_ERR = 3'd4;

    localparam logic [1:0] REG_SLOTS = 2'd0;
    localparam logic [1:0] REG_SKIP  = 2'd1;
    localparam logic [1:0] REG_SCAN  = 2'd2;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  slot;
        logic [63:0] stamp;
        logic        slot_good;
        logic        write_ok;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  found_slot;
        logic [63:0] found_stamp;
    } t_out;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_CHK,
        S_SEARCH,
        S_BS_HI,
        S_BS_MID,
        S_TOP,
        S_WALK,
        S_DONE
    } t_state;

endpackage

FILE: hdl/journal_ring_index_manager.sv
// journal ring index manager
// load/append/latest/index/reset head pass read, check and done states to a result
// next/previous alternate check and search states until hit, not found or too many bad
// recover: head check, else binary search and walk back of at most scan_limit slots
// throughput: one item at a time, next input beat taken the cycle after the result beat
// after reset a clearing pass writes all MAX_SLOTS slots before the first beat
module journal_ring_index_manager import jrim_pkg::*; #(
    parameter int MAX_SLOTS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out        o_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);
    localparam int AW = $clog2(MAX_SLOTS);
    localparam int CW = (AW + 1 > 10) ? AW + 1 : 10;
    localparam logic [CW-1:0] MAXN = CW'(MAX_SLOTS);

    logic [64:0] r_mem [MAX_SLOTS];
    logic [64:0] r_rd;

    t_state r_state, n_state;
    t_in  r_in;
    logic [8:0] r_slots_cfg;
    logic [7:0] r_skip_lim, r_scan_lim;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_latest_slot;
    logic [63:0] r_latest_stamp;
    logic [CW-1:0] r_ptr, r_lo, r_hi, r_mid, r_cnt;
    logic [63:0] r_ts_hi;
    logic [8:0] r_bad;
    logic [7:0] r_walk;
    logic r_out_v;
    t_out r_out;

    logic [CW-1:0] n_clamp;
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [64:0]   mem_wd;

    always_comb begin
        n_clamp = (r_slots_cfg < 9'd2) ? CW'(2) : CW'(r_slots_cfg);
        if (CW'(r_slots_cfg) > MAXN) n_clamp = MAXN;
    end

    function automatic logic [CW-1:0] f_next(input logic [CW-1:0] s,
                                             input logic [CW-1:0] n);
        f_next = (s + 1'b1 > n - 1'b1) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [CW-1:0] f_prev(input logic [CW-1:0] s,
                                             input logic [CW-1:0] n);
        f_prev = (s == '0 || s - 1'b1 > n - 1'b1) ? n - 1'b1 : s - 1'b1;
    endfunction

    logic          rd_ok;
    logic [63:0]   rd_scan;
    logic          newer;
    logic          in_ring_ptr;
    logic          idle_take;
    logic          hit, too_many, head_ok, walk_more;

    assign newer       = (r_in.command == CMD_NEXT);
    assign in_ring_ptr = r_ptr < r_n;
    assign rd_ok       = in_ring_ptr && r_rd[64];
    assign rd_scan     = rd_ok ? r_rd[63:0] : 64'd0;
    assign o_stall     = (r_state != S_IDLE) || r_out_v;
    assign idle_take   = i_valid && !o_stall;
    assign o_valid     = r_out_v;
    assign o_data      = r_out;
    assign hit         = newer ? (r_rd[63:0] > r_in.stamp) : (r_rd[63:0] < r_in.stamp);
    assign too_many    = (r_bad + 1'b1) > {1'b0, r_skip_lim};
    assign head_ok     = rd_ok && (r_rd[63:0] == r_latest_stamp);
    assign walk_more   = (rd_scan == 64'd0) && (r_walk < r_scan_lim)
                         && (CW'(r_walk) < r_n - 1'b1);

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rd <= r_mem[mem_ra];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_ptr == MAXN - 1'b1) n_state = S_IDLE;
            S_IDLE:   if (idle_take) n_state = S_RD;
            S_RD:     n_state = S_CHK;
            S_CHK: begin
                unique case (r_in.command) inside
                    CMD_NEXT, CMD_PREV: begin
                        if (r_cnt >= r_n - 1'b1) n_state = S_DONE;
                        else if (!rd_ok) n_state = too_many ? S_DONE : S_SEARCH;
                        else n_state = hit ? S_DONE : S_SEARCH;
                    end
                    CMD_RECOVER: n_state = head_ok ? S_DONE : S_BS_HI;
                    default: n_state = S_DONE;
                endcase
            end
            S_SEARCH: n_state = S_CHK;
            S_BS_HI:  if (r_cnt[0]) n_state = (r_lo >= r_hi) ? S_TOP : S_BS_MID;
            S_BS_MID: if (r_cnt[0]) begin
                if (rd_scan > r_ts_hi) begin
                    if (r_mid + 1'b1 >= r_hi) n_state = S_TOP;
                end else begin
                    if (r_lo >= r_mid) n_state = S_TOP;
                end
            end
            S_TOP:    n_state = S_WALK;
            S_WALK:   if (r_cnt[0] && !walk_more) n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // memory port control and data path
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_ptr[AW-1:0];
        mem_wd = '0;
        mem_ra = r_ptr[AW-1:0];
        if (r_state == S_CLEAR) mem_we = 1'b1;
        if (r_state == S_BS_MID) mem_ra = r_mid[AW-1:0];
        if (r_state == S_IDLE && idle_take) begin
            if (i_data.command == CMD_LOAD && CW'(i_data.slot) < MAXN) begin
                mem_we = 1'b1;
                mem_wa = AW'(i_data.slot);
                mem_wd = {i_data.slot_good, i_data.stamp};
            end
        end
        if (r_state == S_RD && r_in.command == CMD_APPEND && r_in.write_ok) begin
            mem_we = 1'b1;
            mem_wd = {1'b1, r_latest_stamp + 64'd1};
        end
    end

    logic [CW-1:0] nx_ptr;
    assign nx_ptr = newer ? f_next(r_ptr, r_n) : f_prev(r_ptr, r_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_ptr          <= '0;
            r_out_v        <= 1'b0;
            r_latest_slot  <= '0;
            r_latest_stamp <= '0;
            r_slots_cfg    <= 9'd256;
            r_skip_lim     <= 8'd3;
            r_scan_lim     <= 8'd3;
        end else begin
            r_state <= n_state;
            if (r_out_v && !i_stall) r_out_v <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_SLOTS: r_slots_cfg <= i_cfg_data;
                    REG_SKIP:  r_skip_lim  <= i_cfg_data[7:0];
                    REG_SCAN:  r_scan_lim  <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_CLEAR: r_ptr <= r_ptr + 1'b1;
                S_IDLE: if (idle_take) begin
                    r_in <= i_data;
                    r_n  <= n_clamp;
                    r_out <= '0;
                    unique case (i_data.command)
                        CMD_APPEND: r_ptr <= f_next(r_latest_slot, n_clamp);
                        CMD_NEXT:   r_ptr <= f_next(CW'(i_data.slot), n_clamp);
                        CMD_PREV:   r_ptr <= f_prev(CW'(i_data.slot), n_clamp);
                        CMD_INDEX:  r_ptr <= f_next(CW'(i_data.slot), n_clamp);
                        default:    r_ptr <= r_latest_slot;
                    endcase
                end
                S_RD: begin
                    r_bad <= '0;
                    r_cnt <= '0;
                    unique case (r_in.command)
                        CMD_APPEND: if (r_in.write_ok) begin
                            r_latest_slot  <= r_ptr;
                            r_latest_stamp <= r_latest_stamp + 64'd1;
                            r_out <= '{ST_OK, r_ptr[7:0], r_latest_stamp + 64'd1};
                        end else begin
                            r_out.status <= ST_WRITE_ERR;
                        end
                        CMD_RSTHEAD: begin
                            r_latest_slot  <= '0;
                            r_latest_stamp <= '0;
                        end
                        default: ;
                    endcase
                end
                S_CHK: begin
                    unique case (r_in.command) inside
                        CMD_LATEST:
                            if (rd_ok) r_out <= '{ST_OK, r_ptr[7:0], r_rd[63:0]};
                            else       r_out.status <= ST_NOT_FOUND;
                        CMD_INDEX:
                            if (CW'(r_in.slot) > r_n - 1'b1) r_out.status <= ST_BAD_INDEX;
                            else if (rd_ok) r_out <= '{ST_OK, r_ptr[7:0], r_rd[63:0]};
                            else r_out.status <= ST_NOT_FOUND;
                        CMD_NEXT, CMD_PREV: begin
                            r_ptr   <= nx_ptr;
                            r_cnt   <= r_cnt + 1'b1;
                            if (r_cnt >= r_n - 1'b1) begin
                                r_out.status <= ST_NOT_FOUND;
                            end else if (!rd_ok) begin
                                r_bad <= r_bad + 1'b1;
                                if (too_many) r_out.status <= ST_TOO_MANY;
                            end else begin
                                r_bad <= '0;
                                if (hit) r_out <= '{ST_OK, r_ptr[7:0], r_rd[63:0]};
                            end
                        end
                        CMD_RECOVER:
                            if (head_ok) begin
                                r_out <= '{ST_OK, r_latest_slot[7:0], r_latest_stamp};
                            end else begin
                                r_lo    <= '0;
                                r_hi    <= r_n - 1'b1;
                                r_ptr   <= r_n - 1'b1;
                            end
                        default: ;
                    endcase
                end
                S_BS_HI: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt[0]) begin
                        r_ts_hi <= rd_scan;
                        r_mid   <= r_lo + ((r_hi - r_lo) >> 1);
                        r_ptr   <= r_lo + ((r_hi - r_lo) >> 1);
                    end
                end
                S_BS_MID: begin
                    // waits for read data from the memory, toggled by r_cnt[0]
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt[0]) begin
                        if (rd_scan > r_ts_hi) begin
                            r_lo <= r_mid + 1'b1;
                            if (r_mid + 1'b1 < r_hi) begin
                                r_mid <= r_mid + 1'b1 + ((r_hi - r_mid - 1'b1) >> 1);
                                r_ptr <= r_mid + 1'b1 + ((r_hi - r_mid - 1'b1) >> 1);
                            end
                        end else begin
                            r_hi    <= r_mid;
                            r_ts_hi <= rd_scan;
                            if (r_lo < r_mid) begin
                                r_mid <= r_lo + ((r_mid - r_lo) >> 1);
                                r_ptr <= r_lo + ((r_mid - r_lo) >> 1);
                            end
                        end
                    end
                end
                S_TOP: begin
                    r_ptr  <= (r_lo == '0) ? r_n - 1'b1 : r_lo - 1'b1;
                    r_walk <= '0;
                    r_cnt  <= '0;
                end
                S_WALK: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt[0]) begin
                        if (walk_more) begin
                            r_walk <= r_walk + 1'b1;
                            r_ptr  <= (r_ptr == '0) ? r_n - 1'b1 : r_ptr - 1'b1;
                        end else begin
                            r_latest_slot  <= r_ptr;
                            r_latest_stamp <= rd_scan;
                            r_out <= '{ST_OK, r_ptr[7:0], rd_scan};
                        end
                    end
                end
                S_DONE: r_out_v <= 1'b1;
                default: ;
            endcase
        end
    end

endmodule

FILE: tb/tb_journal_ring_index_manager.sv
module tb_journal_ring_index_manager;
    import jrim_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_in         i_data = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_out        o_data;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = REG_SLOTS;
    logic [8:0]  i_cfg_data = '0;

    journal_ring_index_manager i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // model of the journal index
    logic [63:0] jr_stamp [256];
    bit          jr_good [256];
    int          jr_head_slot;
    logic [63:0] jr_head_stamp;
    int          cfg_slots = 256;
    int          cfg_skip = 3;
    int          cfg_scan = 3;

    t_in  cmd_queue [$];
    t_out result_queue [$];
    int   mismatches = 0;
    int   beats_out = 0;
    int   items_made = 0;
    int   cycles = 0;

    function automatic int ring_size();
        if (cfg_slots < 2) return 2;
        if (cfg_slots > 256) return 256;
        return cfg_slots;
    endfunction

    function automatic bit slot_usable(int s);
        return s < ring_size() && jr_good[s];
    endfunction

    function automatic logic [63:0] scan_value(int s);
        return slot_usable(s) ? jr_stamp[s] : 64'd0;
    endfunction

    function automatic int step_fwd(int s);
        return (s + 1 > ring_size() - 1) ? 0 : s + 1;
    endfunction

    function automatic int step_back(int s);
        return (s == 0 || s - 1 > ring_size() - 1) ? ring_size() - 1 : s - 1;
    endfunction

    function automatic t_out make_result(logic [2:0] st, int s, logic [63:0] ts);
        t_out r;
        r.status = st;
        r.found_slot = s[7:0];
        r.found_stamp = ts;
        return r;
    endfunction

    function automatic t_out ring_search(int marker, logic [63:0] thr, bit newer);
        int n, s, bad;
        n = ring_size();
        s = newer ? step_fwd(marker) : step_back(marker);
        bad = 0;
        for (int i = 0; i < n - 1; i++) begin
            if (!slot_usable(s)) begin
                bad++;
                if (bad > cfg_skip) return make_result(ST_TOO_MANY, 0, 0);
            end else begin
                bad = 0;
                if (newer ? (jr_stamp[s] > thr) : (jr_stamp[s] < thr))
                    return make_result(ST_OK, s, jr_stamp[s]);
            end
            s = newer ? step_fwd(s) : step_back(s);
        end
        return make_result(ST_NOT_FOUND, 0, 0);
    endfunction

    function automatic void recover_head();
        int n, lo, hi, mid, top;
        logic [63:0] ts_hi, ts_mid;
        n = ring_size();
        lo = 0;
        hi = n - 1;
        ts_hi = scan_value(hi);
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            ts_mid = scan_value(mid);
            if (ts_mid > ts_hi) begin
                lo = mid + 1;
            end else begin
                hi = mid;
                ts_hi = ts_mid;
            end
        end
        top = (lo + n - 1) % n;
        jr_head_stamp = scan_value(top);
        for (int i = 0; i < cfg_scan && jr_head_stamp == 0 && i < n - 1; i++) begin
            top = (top + n - 1) % n;
            jr_head_stamp = scan_value(top);
        end
        jr_head_slot = top;
    endfunction

    function automatic t_out journal_predict(t_in it);
        int n, s;
        n = ring_size();
        case (t_cmd'(it.command))
            CMD_LOAD: begin
                jr_stamp[it.slot] = it.stamp;
                jr_good[it.slot] = it.slot_good;
                return make_result(ST_OK, 0, 0);
            end
            CMD_APPEND: begin
                if (!it.write_ok) return make_result(ST_WRITE_ERR, 0, 0);
                s = step_fwd(jr_head_slot);
                jr_head_stamp = jr_head_stamp + 64'd1;
                jr_head_slot = s;
                jr_stamp[s] = jr_head_stamp;
                jr_good[s] = 1'b1;
                return make_result(ST_OK, s, jr_head_stamp);
            end
            CMD_LATEST: begin
                if (slot_usable(jr_head_slot))
                    return make_result(ST_OK, jr_head_slot, jr_stamp[jr_head_slot]);
                return make_result(ST_NOT_FOUND, 0, 0);
            end
            CMD_NEXT: return ring_search(it.slot, it.stamp, 1'b1);
            CMD_PREV: return ring_search(it.slot, it.stamp, 1'b0);
            CMD_INDEX: begin
                if (it.slot > n - 1) return make_result(ST_BAD_INDEX, 0, 0);
                s = (it.slot + 1 > n - 1) ? 0 : it.slot + 1;
                if (slot_usable(s)) return make_result(ST_OK, s, jr_stamp[s]);
                return make_result(ST_NOT_FOUND, 0, 0);
            end
            CMD_RECOVER: begin
                if (!slot_usable(jr_head_slot) || jr_stamp[jr_head_slot] != jr_head_stamp)
                    recover_head();
                return make_result(ST_OK, jr_head_slot, jr_head_stamp);
            end
            default: begin
                jr_head_slot = 0;
                jr_head_stamp = 0;
                return make_result(ST_OK, 0, 0);
            end
        endcase
    endfunction

    // sender: bursts and gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) result_queue.push_back(journal_predict(i_data));
            if (i_valid && o_stall) begin
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else if (cmd_queue.size() > 0) begin
                i_data <= cmd_queue.pop_front();
                i_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern, with one long hold-off
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    int  rx_run = 0;
    bit  rx_mode = 1'b0;

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else if (!hold_done && beats_out >= 300) begin
            hold_done <= 1'b1;
            hold_left <= 3000;
            i_stall <= 1'b1;
        end else if (rx_run == 0) begin
            rx_run <= $urandom_range(1, 30);
            rx_mode <= ($urandom_range(0, 3) == 0);
            i_stall <= rx_mode;
        end else begin
            rx_run <= rx_run - 1;
            i_stall <= rx_mode;
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            beats_out <= beats_out + 1;
            if (result_queue.size() == 0) begin
                $error("unexpected result beat status=%0d", o_data.status);
                mismatches++;
            end else begin
                want = result_queue.pop_front();
                if (want.status !== o_data.status) begin
                    $error("status expected %0d actual %0d", want.status, o_data.status);
                    mismatches++;
                end
                if (want.found_slot !== o_data.found_slot) begin
                    $error("found_slot expected %0d actual %0d",
                           want.found_slot, o_data.found_slot);
                    mismatches++;
                end
                if (want.found_stamp !== o_data.found_stamp) begin
                    $error("found_stamp expected %h actual %h",
                           want.found_stamp, o_data.found_stamp);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic add_cmd(t_cmd c, int s, logic [63:0] ts, bit good, bit wok);
        t_in it;
        it.command = c;
        it.slot = s[7:0];
        it.stamp = ts;
        it.slot_good = good;
        it.write_ok = wok;
        cmd_queue.push_back(it);
        items_made++;
    endtask

    task automatic write_reg(logic [1:0] idx, int value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value[8:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_SLOTS: cfg_slots = value & 9'h1ff;
            REG_SKIP:  cfg_skip = value & 8'hff;
            default:   cfg_scan = value & 8'hff;
        endcase
    endtask

    task automatic wait_drained();
        while (cmd_queue.size() != 0 || i_valid || result_queue.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic random_phase(int count);
        int n, rot, fill, s, pick;
        logic [63:0] base;
        n = ring_size();
        rot = $urandom_range(0, n - 1);
        fill = (n > 40) ? 40 : n;
        case ($urandom_range(0, 3))
            0: base = rand64();
            1: base = 64'hffff_ffff_ffff_fff0;
            default: base = $urandom_range(0, 1000);
        endcase
        if ($urandom_range(0, 4) == 0) add_cmd(CMD_RSTHEAD, $urandom, rand64(), 0, 0);
        for (int i = 0; i < fill; i++)
            add_cmd(CMD_LOAD, (rot + i) % n, base + i, $urandom_range(0, 9) != 0,
                    $urandom_range(0, 1));
        add_cmd(CMD_RECOVER, $urandom, rand64(), $urandom_range(0, 1), $urandom_range(0, 1));
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 19);
            s = $urandom_range(0, n - 1);
            if (pick < 4) begin
                add_cmd(CMD_APPEND, $urandom, rand64(), $urandom_range(0, 1),
                        $urandom_range(0, 4) != 0);
            end else if (pick < 7) begin
                add_cmd(CMD_NEXT, s, base + $urandom_range(0, fill + 2) - 1,
                        $urandom_range(0, 1), $urandom_range(0, 1));
            end else if (pick < 10) begin
                add_cmd(CMD_PREV, s, base + $urandom_range(0, fill + 2) - 1,
                        $urandom_range(0, 1), $urandom_range(0, 1));
            end else if (pick < 12) begin
                add_cmd(CMD_INDEX, $urandom_range(0, 3) == 0 ? $urandom : s, rand64(),
                        $urandom_range(0, 1), $urandom_range(0, 1));
            end else if (pick < 14) begin
                add_cmd(CMD_RECOVER, $urandom, rand64(), $urandom_range(0, 1),
                        $urandom_range(0, 1));
            end else if (pick == 14) begin
                add_cmd(CMD_LATEST, $urandom, rand64(), $urandom_range(0, 1),
                        $urandom_range(0, 1));
            end else if (pick == 15) begin
                add_cmd(CMD_LOAD, s, base + $urandom_range(0, 60), $urandom_range(0, 1),
                        $urandom_range(0, 1));
            end else if (pick == 16) begin
                add_cmd(CMD_RSTHEAD, $urandom, rand64(), $urandom_range(0, 1),
                        $urandom_range(0, 1));
            end else begin
                add_cmd(t_cmd'($urandom_range(0, 7)), $urandom, rand64(),
                        $urandom_range(0, 1), $urandom_range(0, 1));
            end
        end
    endtask

    initial begin
        int p;
        foreach (jr_stamp[k]) begin
            jr_stamp[k] = '0;
            jr_good[k] = 1'b0;
        end
        jr_head_slot = 0;
        jr_head_stamp = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);

        write_reg(REG_SLOTS, 256);
        write_reg(REG_SKIP, 3);
        write_reg(REG_SCAN, 3);
        add_cmd(CMD_LATEST, 0, 0, 0, 0);
        add_cmd(CMD_RECOVER, 0, 0, 0, 0);
        add_cmd(CMD_LOAD, 0, 64'd0, 1, 0);
        add_cmd(CMD_LOAD, 255, 64'hffff_ffff_ffff_ffff, 1, 1);
        add_cmd(CMD_LOAD, 5, 64'd100, 0, 1);
        add_cmd(CMD_APPEND, 0, 0, 0, 0);
        add_cmd(CMD_APPEND, 0, 0, 1, 1);
        add_cmd(CMD_LATEST, 0, 0, 0, 0);
        add_cmd(CMD_NEXT, 0, 64'd0, 0, 0);
        add_cmd(CMD_NEXT, 255, 64'd0, 0, 0);
        add_cmd(CMD_PREV, 0, 64'hffff_ffff_ffff_ffff, 0, 0);
        add_cmd(CMD_PREV, 1, 64'd1, 0, 0);
        add_cmd(CMD_PREV, 200, 64'd0, 0, 0);
        add_cmd(CMD_NEXT, 2, 64'hffff_ffff_ffff_ffff, 0, 0);
        add_cmd(CMD_INDEX, 0, 0, 0, 0);
        add_cmd(CMD_INDEX, 254, 0, 0, 0);
        add_cmd(CMD_INDEX, 255, 0, 0, 0);
        add_cmd(CMD_INDEX, 3, 0, 0, 0);
        add_cmd(CMD_RECOVER, 0, 0, 0, 0);
        add_cmd(CMD_RSTHEAD, 255, 64'hffff_ffff_ffff_ffff, 1, 1);
        add_cmd(CMD_RECOVER, 0, 0, 0, 0);
        add_cmd(CMD_LOAD, 0, 64'd7, 0, 0);
        add_cmd(CMD_RECOVER, 0, 0, 0, 0);
        add_cmd(CMD_LATEST, 0, 0, 0, 0);
        wait_drained();

        p = 0;
        while (items_made < 1050) begin
            case (p)
                0: begin write_reg(REG_SLOTS, 2); write_reg(REG_SKIP, 0);
                         write_reg(REG_SCAN, 0); end
                1: begin write_reg(REG_SLOTS, 256); write_reg(REG_SKIP, 255);
                         write_reg(REG_SCAN, 255); end
                2: begin write_reg(REG_SLOTS, 0); write_reg(REG_SKIP, 1);
                         write_reg(REG_SCAN, 1); end
                3: begin write_reg(REG_SLOTS, 511); write_reg(REG_SKIP, 0);
                         write_reg(REG_SCAN, 255); end
                4: begin write_reg(REG_SLOTS, 255); write_reg(REG_SKIP, 2);
                         write_reg(REG_SCAN, 0); end
                default: begin
                    write_reg(REG_SLOTS, $urandom_range(2, 32));
                    write_reg(REG_SKIP, $urandom_range(0, 3) == 0 ? 255 : $urandom_range(0, 4));
                    write_reg(REG_SCAN, $urandom_range(0, 3) == 0 ? 255 : $urandom_range(0, 4));
                end
            endcase
            random_phase($urandom_range(20, 50));
            wait_drained();
            p++;
        end

        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && result_queue.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
